// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the scheduler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define AST_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scheduler check failed");

// clocked assertion that also holds during reset
`define AST_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scheduler check failed");

`endif

// ===== rtl/core/mfqs_pkg.sv =====
package mfqs_pkg;

  localparam int DEF_LEVELS   = 3;
  localparam int DEF_MAX_JOBS = 16;
  localparam int JOB_W        = 4;
  localparam int LVL_W        = 2;
  localparam int STAT_W       = 3;
  localparam int CNT_W        = 16;
  localparam logic [CNT_W-1:0] BOOST_RESET = 16'd5000;
  localparam logic [2:0] REG_BOOST_PERIOD = 3'd0;

  typedef enum logic [2:0] {
    MODE_FORK     = 3'd0,
    MODE_DISPATCH = 3'd1,
    MODE_DEMOTE   = 3'd2,
    MODE_COMPLETE = 3'd3,
    MODE_BOOST    = 3'd4,
    MODE_TICK     = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NO_IDS  = 3'd2,
    ST_BAD_JOB = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_DISP_RES,
    CMD_JOB_RES,
    CMD_BSCAN,
    CMD_BID,
    CMD_BCHK,
    CMD_BEND,
    CMD_FIN
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       disp_any;
    logic       job_ok;
    logic       tick_fire;
    logic       scan_end;
    logic       scan_more;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/multilevel_feedback_queue_scheduler.sv =====
// multilevel feedback queue scheduler
// in channel: one transaction per command, in_tuser carries the mode, in_tdata the job id
// out channel: exactly one result transaction per command, in command order
// cfg port: apb-style, register 0 at byte address 0 is the boost period (reset 5000)
// a command is taken only while the sequencer is idle; it then runs to completion
// fork, empty dispatch, invalid demote or complete, unused modes and ticks without a boost
//   go from the execute step straight to the final step; other dispatch, demote and
//   complete commands pass through a wait step for their memory read in between
// boost (direct or on tick expiry) walks every queued entry through the entry
//   memory and the job table, with a scan, id and check step per entry
// the next command can be accepted in the same cycle as the result is offered, but
//   not before the previous command has reached its final step
// each sequencer step makes at most one read of the entry memory and one of the
//   job table, each of which has a single read port
// reset clears all queues, the job live marks, the id allocator and the countdown; the
//   entry memory needs no clearing
// when out_tready is low the finished result waits in the output register; the
//   next command may already be accepted and is held at its final step until then
module multilevel_feedback_queue_scheduler import mfqs_pkg::*; #(
  parameter int LEVELS   = DEF_LEVELS,
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] job_id, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] result_job, [5:4] result_level, [8:6] status
  output logic [1:0]  out_tuser,  // [0] found, [1] boosted
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t       cmd;
  dp_status_t st;
  logic [CNT_W-1:0]  interval_r;
  logic [JOB_W-1:0]  o_job;
  logic [LVL_W-1:0]  o_level;
  logic              o_found, o_boosted;
  logic [STAT_W-1:0] o_status;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_BOOST_PERIOD) ? {16'd0, interval_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= BOOST_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_BOOST_PERIOD) begin
      interval_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  mfqs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .st(st), .cmd(cmd)
  );

  mfqs_datapath #(.LEVELS(LEVELS), .MAX_JOBS(MAX_JOBS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_mode(in_tuser), .in_job_id(in_tdata[3:0]), .interval(interval_r),
    .out_ready(out_tready), .out_valid(out_tvalid),
    .out_job(o_job), .out_level(o_level), .out_found(o_found),
    .out_boosted(o_boosted), .out_status(o_status)
  );

  assign out_tdata = {7'd0, o_status, o_level, o_job};
  assign out_tuser = {o_boosted, o_found};

endmodule

// ===== rtl/core/mfqs_ram.sv =====
module mfqs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mfqs_ctrl.sv =====
module mfqs_ctrl import mfqs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t st,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DWAIT, S_JWAIT, S_BSCAN, S_BID, S_BCHK, S_BEND, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd       = CMD_EXEC;
        state_nxt = S_FIN;
        priority if (st.mode == MODE_DISPATCH && st.disp_any) begin
          state_nxt = S_DWAIT;
        end else if ((st.mode == MODE_DEMOTE || st.mode == MODE_COMPLETE) && st.job_ok) begin
          state_nxt = S_JWAIT;
        end else if (st.mode == MODE_BOOST || (st.mode == MODE_TICK && st.tick_fire)) begin
          state_nxt = S_BSCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DWAIT: begin
        cmd       = CMD_DISP_RES;
        state_nxt = S_FIN;
      end
      S_JWAIT: begin
        cmd       = CMD_JOB_RES;
        state_nxt = S_FIN;
      end
      S_BSCAN: begin
        cmd = CMD_BSCAN;
        priority if (st.scan_end) begin
          state_nxt = S_BEND;
        end else if (st.scan_more) begin
          state_nxt = S_BID;
        end else begin
          state_nxt = S_BSCAN;
        end
      end
      S_BID: begin
        cmd       = CMD_BID;
        state_nxt = S_BCHK;
      end
      S_BCHK: begin
        cmd       = CMD_BCHK;
        state_nxt = S_BSCAN;
      end
      S_BEND: begin
        cmd       = CMD_BEND;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd       = CMD_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/mfqs_datapath.sv =====
module mfqs_datapath import mfqs_pkg::*; #(
  parameter int LEVELS   = DEF_LEVELS,
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output dp_status_t        st,
  input  logic [2:0]        in_mode,
  input  logic [JOB_W-1:0]  in_job_id,
  input  logic [CNT_W-1:0]  interval,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [JOB_W-1:0]  out_job,
  output logic [LVL_W-1:0]  out_level,
  output logic              out_found,
  output logic              out_boosted,
  output logic [STAT_W-1:0] out_status
);

  localparam int IDW = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int LW  = $clog2(LEVELS);
  localparam int SD  = LEVELS * MAX_JOBS;
  localparam int SAW = $clog2(SD);
  localparam int JDW = LW + 1;

  logic [IDW-1:0]   head_r [LEVELS];
  logic [CW-1:0]    cnt_r  [LEVELS];
  logic [MAX_JOBS-1:0] live_r;
  logic [CW-1:0]    next_id_r;
  logic [CNT_W-1:0] countdown_r;
  logic [2:0]       mode_r;
  logic [JOB_W-1:0] jid_r;
  logic [LW:0]      lv_r;
  logic [CW-1:0]    k_r;
  logic [CW-1:0]    n_r;
  logic             over_r;
  logic [IDW-1:0]   id_r;

  logic [JOB_W-1:0]  res_job_r;
  logic [LVL_W-1:0]  res_level_r;
  logic              res_found_r;
  logic              res_boosted_r;
  logic [STAT_W-1:0] res_status_r;
  logic              out_valid_r;

  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [IDW-1:0] s_wdata, s_rdata;
  logic           j_we;
  logic [IDW-1:0] j_waddr, j_raddr;
  logic [JDW-1:0] j_wdata, j_rdata;

  logic           disp_any;
  logic [LW-1:0]  disp_lv;
  logic [IDW-1:0] jid_idx;
  logic           job_ok;
  logic [LW-1:0]  cur_lv, new_lv, scan_lv;
  logic           scan_end, scan_more;

  function automatic logic [IDW-1:0] wrap_pos(input logic [IDW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(c);
    if (s >= (CW+1)'(MAX_JOBS)) begin
      s = s - (CW+1)'(MAX_JOBS);
    end
    return IDW'(s);
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [LW-1:0] lv, input logic [IDW-1:0] pos);
    return SAW'(lv * MAX_JOBS) + SAW'(pos);
  endfunction

  mfqs_ram #(.WIDTH(IDW), .DEPTH(SD)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // per job: done mark above the level
  mfqs_ram #(.WIDTH(JDW), .DEPTH(MAX_JOBS)) u_jobs (
    .clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
    .raddr(j_raddr), .rdata(j_rdata)
  );

  always_comb begin
    disp_any = 1'b0;
    disp_lv  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        disp_any = 1'b1;
        disp_lv  = LW'(i);
      end
    end
  end

  assign jid_idx   = IDW'(jid_r);
  assign job_ok    = (9'(jid_r) < 9'(MAX_JOBS)) && live_r[jid_idx];
  assign cur_lv    = j_rdata[LW-1:0];
  assign new_lv    = ((JDW)'(cur_lv) + JDW'(1) < JDW'(LEVELS)) ? cur_lv + LW'(1) : cur_lv;
  assign scan_end  = (lv_r >= (LW+1)'(LEVELS));
  assign scan_lv   = LW'(lv_r);
  assign scan_more = !scan_end && (k_r < cnt_r[scan_lv]);

  assign st.mode      = mode_r;
  assign st.disp_any  = disp_any;
  assign st.job_ok    = job_ok;
  assign st.tick_fire = (countdown_r <= CNT_W'(1));
  assign st.scan_end  = scan_end;
  assign st.scan_more = scan_more;
  assign st.out_free  = !out_valid_r || out_ready;

  // memory ports
  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    j_we    = 1'b0;
    j_waddr = '0;
    j_wdata = '0;
    j_raddr = '0;
    unique case (cmd)
      CMD_EXEC: begin
        unique case (mode_r)
          MODE_FORK: begin
            if (next_id_r < CW'(MAX_JOBS) && cnt_r[0] < CW'(MAX_JOBS)) begin
              s_we    = 1'b1;
              s_waddr = saddr('0, wrap_pos(head_r[0], cnt_r[0]));
              s_wdata = IDW'(next_id_r);
              j_we    = 1'b1;
              j_waddr = IDW'(next_id_r);
              j_wdata = '0;
            end
          end
          MODE_DISPATCH: s_raddr = saddr(disp_lv, head_r[disp_lv]);
          MODE_DEMOTE, MODE_COMPLETE: j_raddr = jid_idx;
          default: ;
        endcase
      end
      CMD_JOB_RES: begin
        if (mode_r == MODE_COMPLETE) begin
          j_we    = 1'b1;
          j_waddr = id_r;
          j_wdata = {1'b1, cur_lv};
        end else if (cnt_r[new_lv] < CW'(MAX_JOBS)) begin
          s_we    = 1'b1;
          s_waddr = saddr(new_lv, wrap_pos(head_r[new_lv], cnt_r[new_lv]));
          s_wdata = id_r;
          j_we    = 1'b1;
          j_waddr = id_r;
          j_wdata = {j_rdata[LW], new_lv};
        end
      end
      CMD_BSCAN: begin
        if (scan_more) begin
          s_raddr = saddr(scan_lv, wrap_pos(head_r[scan_lv], k_r));
        end
      end
      CMD_BID: j_raddr = s_rdata;
      CMD_BCHK: begin
        // survivors refill level 0 behind its head, over slots already read or free
        if (live_r[id_r] && !j_rdata[LW] && n_r < CW'(MAX_JOBS)) begin
          s_we    = 1'b1;
          s_waddr = saddr('0, wrap_pos(head_r[0], n_r));
          s_wdata = id_r;
          j_we    = 1'b1;
          j_waddr = id_r;
          j_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      live_r      <= '0;
      next_id_r   <= '0;
      countdown_r <= BOOST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        CMD_LOAD: begin
          mode_r <= in_mode;
          jid_r  <= in_job_id;
        end
        CMD_EXEC: begin
          res_job_r     <= '0;
          res_level_r   <= '0;
          res_found_r   <= 1'b0;
          res_boosted_r <= 1'b0;
          res_status_r  <= ST_OK;
          lv_r          <= '0;
          k_r           <= '0;
          n_r           <= '0;
          over_r        <= 1'b0;
          unique case (mode_r)
            MODE_FORK: begin
              priority if (next_id_r >= CW'(MAX_JOBS)) begin
                res_status_r <= ST_NO_IDS;
              end else if (cnt_r[0] >= CW'(MAX_JOBS)) begin
                res_status_r <= ST_FULL;
              end else begin
                cnt_r[0]                 <= cnt_r[0] + CW'(1);
                live_r[IDW'(next_id_r)]  <= 1'b1;
                res_job_r                <= JOB_W'(next_id_r);
                res_found_r              <= 1'b1;
                next_id_r                <= next_id_r + CW'(1);
              end
            end
            MODE_DISPATCH: begin
              if (!disp_any) begin
                res_status_r <= ST_EMPTY;
              end else begin
                head_r[disp_lv] <= wrap_pos(head_r[disp_lv], CW'(1));
                cnt_r[disp_lv]  <= cnt_r[disp_lv] - CW'(1);
                res_level_r     <= LVL_W'(disp_lv);
                res_found_r     <= 1'b1;
              end
            end
            MODE_DEMOTE, MODE_COMPLETE: begin
              if (!job_ok) begin
                res_status_r <= ST_BAD_JOB;
              end
              id_r <= jid_idx;
            end
            MODE_TICK: begin
              if (countdown_r <= CNT_W'(1)) begin
                countdown_r <= (interval == '0) ? CNT_W'(1) : interval;
              end else begin
                countdown_r <= countdown_r - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
        CMD_DISP_RES: res_job_r <= JOB_W'(s_rdata);
        CMD_JOB_RES: begin
          if (mode_r == MODE_COMPLETE) begin
            res_job_r   <= JOB_W'(id_r);
            res_level_r <= LVL_W'(cur_lv);
            res_found_r <= 1'b1;
          end else if (cnt_r[new_lv] >= CW'(MAX_JOBS)) begin
            res_status_r <= ST_FULL;
          end else begin
            cnt_r[new_lv] <= cnt_r[new_lv] + CW'(1);
            res_job_r     <= JOB_W'(id_r);
            res_level_r   <= LVL_W'(new_lv);
            res_found_r   <= 1'b1;
          end
        end
        CMD_BSCAN: begin
          if (scan_more) begin
            k_r <= k_r + CW'(1);
          end else if (!scan_end) begin
            lv_r <= lv_r + (LW+1)'(1);
            k_r  <= '0;
          end
        end
        CMD_BID: id_r <= s_rdata;
        CMD_BCHK: begin
          if (live_r[id_r] && !j_rdata[LW]) begin
            if (n_r < CW'(MAX_JOBS)) begin
              n_r <= n_r + CW'(1);
            end else begin
              over_r <= 1'b1;
            end
          end
        end
        CMD_BEND: begin
          for (int i = 1; i < LEVELS; i++) begin
            cnt_r[i] <= '0;
          end
          cnt_r[0]      <= n_r;
          res_boosted_r <= (n_r != '0);
          res_status_r  <= over_r ? ST_FULL : ST_OK;
        end
        CMD_FIN: begin
          out_job     <= res_job_r;
          out_level   <= res_level_r;
          out_found   <= res_found_r;
          out_boosted <= res_boosted_r;
          out_status  <= res_status_r;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/mfqs_checker.sv =====
`include "assert_macros.svh"

module mfqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result stays offered
  `AST_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  // a found job always comes with ok status
  `AST_CLK(a_found_ok, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata[8:6] == 3'd0)
  // without a found job the job and level fields read zero
  `AST_CLK(a_nofound_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata[5:0] == 6'd0)
  // a boost never reports a found job
  `AST_CLK(a_boost_excl, clk, rst_n, out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
  // nothing is offered in reset
  `AST_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid)

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_mfqs_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
